// ----- rtl/core/mpf_pkg.sv -----
`default_nettype none

package mpf_pkg;

   localparam int MAX_LEVELS  = 8;
   localparam int LEVEL_DEPTH = 16;
   localparam int DATA_WIDTH  = 32;

   localparam int OP_W     = 2;
   localparam int LEVEL_W  = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int TOTAL_W  = 8;
   localparam int ACTIVE_W = 4;
   localparam int LIM_W    = ACTIVE_W + 1;

   localparam int LVL_W   = $clog2(MAX_LEVELS);
   localparam int PTR_W   = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
   localparam int STORE_DEPTH = MAX_LEVELS * LEVEL_DEPTH;
   localparam int ADDR_W  = $clog2(STORE_DEPTH);

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(8);

   localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
   localparam logic [OP_W-1:0] OP_POP  = 2'd1;
   localparam logic [OP_W-1:0] OP_TERM = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DRAINED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BADLEVEL = 3'd3;
   localparam logic [STATUS_W-1:0] ST_STOPPED  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

   typedef struct packed {
      logic accept;
      logic load_pop;
      logic move;
   } mpf_cmd_type;

   typedef struct packed {
      logic pop_hit;
   } mpf_stat_type;

endpackage

`default_nettype wire

// ----- rtl/core/mpf_ram.sv -----
`default_nettype none

module mpf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/core/mpf_ctrl.sv -----
`default_nettype none

module mpf_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire mpf_pkg::mpf_stat_type stat,
   output mpf_pkg::mpf_cmd_type       cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic state_ff, state_in;
   logic res_valid_ff, res_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic move, accept, load_res;

   always_comb begin
      move       = res_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready = (state_ff == S_IDLE) && (!res_valid_ff || move);
      accept     = req_tvalid && req_tready;
      load_res   = 1'b0;
      state_in   = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (stat.pop_hit) begin
                  state_in = S_READ;
               end else begin
                  load_res = 1'b1;
               end
            end
         end
         S_READ: begin
            load_res = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load_res) begin
         res_valid_in = 1'b1;
      end else if (move) begin
         res_valid_in = 1'b0;
      end else begin
         res_valid_in = res_valid_ff;
      end

      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      cmd.accept   = accept;
      cmd.load_pop = (state_ff == S_READ);
      cmd.move     = move;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         res_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_valid_ff <= res_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- rtl/core/mpf_datapath.sv -----
`default_nettype none

module mpf_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [mpf_pkg::ACTIVE_W-1:0]        csr_wdata,
   input  wire logic [mpf_pkg::OP_W-1:0]            op,
   input  wire logic [mpf_pkg::LEVEL_W-1:0]         level,
   input  wire logic [mpf_pkg::VALUE_W-1:0]         value,
   input  wire mpf_pkg::mpf_cmd_type                cmd,
   output mpf_pkg::mpf_stat_type                    stat,
   output logic      [mpf_pkg::STATUS_W-1:0]        status,
   output logic      [mpf_pkg::VALUE_W-1:0]         pop_value,
   output logic      [mpf_pkg::TOTAL_W-1:0]         total_length,
   output logic                                     empty_flag
);

   localparam int NL = mpf_pkg::MAX_LEVELS;

   logic [mpf_pkg::ACTIVE_W-1:0] active_ff;
   logic [mpf_pkg::PTR_W-1:0]    head_ff [NL];
   logic [mpf_pkg::PTR_W-1:0]    tail_ff [NL];
   logic [mpf_pkg::CNT_W-1:0]    cnt_ff  [NL];
   logic [mpf_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic                         stopped_ff, stopped_in;

   logic [mpf_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [mpf_pkg::VALUE_W-1:0]  res_value_ff;
   logic [mpf_pkg::TOTAL_W-1:0]  res_total_ff;
   logic                         res_empty_ff;

   logic [mpf_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [mpf_pkg::VALUE_W-1:0]  rsp_value_ff;
   logic [mpf_pkg::TOTAL_W-1:0]  rsp_total_ff;
   logic                         rsp_empty_ff;

   logic [mpf_pkg::LIM_W-1:0]    lim;
   logic                         lvl_bad;
   logic [mpf_pkg::LVL_W-1:0]    lvl_idx;
   logic                         found;
   logic [mpf_pkg::LVL_W-1:0]    sel;
   logic                         do_push, do_pop;

   logic                         ram_we;
   logic [mpf_pkg::ADDR_W-1:0]   ram_addr;
   logic [mpf_pkg::DATA_WIDTH-1:0] ram_wdata, ram_rdata;

   function automatic logic [mpf_pkg::PTR_W-1:0] next_slot(
      input logic [mpf_pkg::PTR_W-1:0] p
   );
      logic [mpf_pkg::PTR_W-1:0] r;
      if (int'(p) + 1 >= mpf_pkg::LEVEL_DEPTH) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      if ({1'b0, active_ff} > mpf_pkg::LIM_W'(NL)) begin
         lim = mpf_pkg::LIM_W'(NL);
      end else begin
         lim = {1'b0, active_ff};
      end
      lvl_bad = (mpf_pkg::LIM_W'(level) >= lim) || (int'(level) >= NL);
      lvl_idx = mpf_pkg::LVL_W'(level);

      found = 1'b0;
      sel   = '0;
      for (int i = 0; i < NL; i++) begin
         if (!found && (i < int'(lim)) && (cnt_ff[i] != '0)) begin
            found = 1'b1;
            sel   = mpf_pkg::LVL_W'(i);
         end
      end

      do_push       = 1'b0;
      do_pop        = 1'b0;
      res_status_in = mpf_pkg::ST_OK;
      stopped_in    = stopped_ff;
      total_in      = total_ff;
      case (op)
         mpf_pkg::OP_PUSH: begin
            if (lvl_bad) begin
               res_status_in = mpf_pkg::ST_BADLEVEL;
            end else if (stopped_ff) begin
               res_status_in = mpf_pkg::ST_STOPPED;
            end else if (cnt_ff[lvl_idx] >= mpf_pkg::CNT_W'(mpf_pkg::LEVEL_DEPTH)) begin
               res_status_in = mpf_pkg::ST_FULL;
            end else begin
               do_push  = 1'b1;
               total_in = total_ff + 1'b1;
            end
         end
         mpf_pkg::OP_POP: begin
            if (found) begin
               do_pop   = 1'b1;
               total_in = total_ff - 1'b1;
            end else if (stopped_ff && (total_ff == '0)) begin
               res_status_in = mpf_pkg::ST_DRAINED;
            end else begin
               res_status_in = mpf_pkg::ST_EMPTY;
            end
         end
         mpf_pkg::OP_TERM: begin
            stopped_in = 1'b1;
         end
         default: begin
         end
      endcase

      stat.pop_hit = do_pop;

      ram_we    = cmd.accept && do_push;
      ram_wdata = mpf_pkg::DATA_WIDTH'(value);
      if (do_push) begin
         ram_addr = mpf_pkg::ADDR_W'(int'(lvl_idx) * mpf_pkg::LEVEL_DEPTH
                                     + int'(tail_ff[lvl_idx]));
      end else begin
         ram_addr = mpf_pkg::ADDR_W'(int'(sel) * mpf_pkg::LEVEL_DEPTH
                                     + int'(head_ff[sel]));
      end
   end

   mpf_ram #(
      .WIDTH (mpf_pkg::DATA_WIDTH),
      .DEPTH (mpf_pkg::STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= mpf_pkg::ACTIVE_RESET;
         total_ff   <= '0;
         stopped_ff <= 1'b0;
         for (int i = 0; i < NL; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         if (csr_we) begin
            active_ff <= csr_wdata;
         end
         if (cmd.accept) begin
            total_ff   <= total_in;
            stopped_ff <= stopped_in;
            if (do_push) begin
               tail_ff[lvl_idx] <= next_slot(tail_ff[lvl_idx]);
               cnt_ff[lvl_idx]  <= cnt_ff[lvl_idx] + 1'b1;
            end
            if (do_pop) begin
               head_ff[sel] <= next_slot(head_ff[sel]);
               cnt_ff[sel]  <= cnt_ff[sel] - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         res_status_ff <= res_status_in;
         res_value_ff  <= '0;
         res_total_ff  <= total_in;
         res_empty_ff  <= (total_in == '0);
      end
      if (cmd.load_pop) begin
         res_value_ff <= mpf_pkg::VALUE_W'(ram_rdata);
      end
      if (cmd.move) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_total_ff  <= res_total_ff;
         rsp_empty_ff  <= res_empty_ff;
      end
   end

   assign status       = rsp_status_ff;
   assign pop_value    = rsp_value_ff;
   assign total_length = rsp_total_ff;
   assign empty_flag   = rsp_empty_ff;

endmodule

`default_nettype wire

// ----- rtl/core/multilevel_priority_fifo.sv -----
// channel  dir  handshake             payload
// req      in   req_tvalid/tready     tuser op, tdata level and value
// rsp      out  rsp_tvalid/tready     tuser status, tdata pop_value, total_length, empty_flag
// csr      in   csr_we                csr_wdata active_levels
//
// push, terminate and failed pops end in the idle state; a successful pop goes on
// to the read state, which waits on the registered read of the entry store memory.
// a result reaches rsp through a result stage and then the output register,
// so a new item is taken while a result waits.
// reset is synchronous: it empties every level and restores active_levels to 8.
// a stall on rsp holds the output; req stalls once the result stage is also full.
`default_nettype none

module multilevel_priority_fifo (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // level[2:0], value[34:3], zero[39:35]
   input  wire logic [1:0]  req_tuser,   // op[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [47:0] rsp_tdata,   // pop_value[31:0], total_length[39:32],
                                         // empty_flag[40], zero[47:41]
   output logic      [2:0]  rsp_tuser,   // status[2:0]
   input  wire logic        csr_we,
   input  wire logic [3:0]  csr_wdata    // active_levels[3:0]
);

   mpf_pkg::mpf_cmd_type  cmd;
   mpf_pkg::mpf_stat_type stat;

   logic [mpf_pkg::VALUE_W-1:0] pop_value;
   logic [mpf_pkg::TOTAL_W-1:0] total_length;
   logic                        empty_flag;

   mpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mpf_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .op           (req_tuser),
      .level        (req_tdata[2:0]),
      .value        (req_tdata[34:3]),
      .cmd          (cmd),
      .stat         (stat),
      .status       (rsp_tuser),
      .pop_value    (pop_value),
      .total_length (total_length),
      .empty_flag   (empty_flag)
   );

   assign rsp_tdata = {7'd0, empty_flag, total_length, pop_value};

endmodule

`default_nettype wire

// ----- rtl/core/mpf_checker.sv -----
`default_nettype none

module mpf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [39:0] req_tdata,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        csr_we,
   input wire logic [3:0]  csr_wdata
);

   logic unused_ok;
   assign unused_ok = ^{req_tvalid, req_tready, req_tdata, req_tuser, csr_we, csr_wdata};

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp item changed");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[40] == (rsp_tdata[39:32] == 8'd0)))
      else $error("empty_flag disagrees with total_length");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != mpf_pkg::ST_OK) |-> (rsp_tdata[31:0] == 32'd0))
      else $error("pop_value nonzero on failed item");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (int'(rsp_tdata[39:32]) <= mpf_pkg::STORE_DEPTH))
      else $error("total_length above capacity");

endmodule

bind multilevel_priority_fifo mpf_checker u_mpf_checker (.*);

`default_nettype wire
